@@ rtl/core/srp_pkg.sv @@
package srp_pkg;

    typedef enum logic [1:0]
    {
        ST_PLACED  = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_IN,
        S_SCAN_NEXT,
        S_CHECK,
        S_BUILD_RD,
        S_BUILD,
        S_DONE
    } fsm_t;

    localparam int REG_ATLAS_WIDTH  = 0;
    localparam int REG_ATLAS_HEIGHT = 1;

endpackage

@@ rtl/core/srp_ram.sv @@
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/skyline_rect_packer_top.sv @@
// A rejected size goes from S_IDLE straight to S_DONE; out_valid is registered from S_DONE.
// Otherwise the scan reads, for each start segment, the segments that cover the width, then
// S_CHECK sends a no fit to S_DONE, and a placement goes through S_BUILD_RD and S_BUILD.
// One request at a time; the next transfer can be taken in the cycle out_valid rises (unless
// cfg_we is high), and a result held by out_stall delays the following one.
// Reset (rst_n, async low): both sizes 1024, one full-width segment, used height 0.
module skyline_rect_packer_top
    import srp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [COORD_BITS:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS:0]   rect_width,
    input  logic [COORD_BITS:0]   rect_height,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [COORD_BITS-1:0] pos_x,
    output logic [COORD_BITS-1:0] pos_y,
    output logic [COORD_BITS:0]   used_height
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 2);
    localparam int VW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 2 * VW;
    localparam logic [VW-1:0] LIMIT = VW'(1) << COORD_BITS;

    fsm_t state_reg, state_next;
    logic [VW-1:0] aw_reg, ah_reg, w_reg, h_reg, hi_reg;
    logic [CW-1:0] cnt_reg, i_reg, j_reg, n_reg, bidx_reg;
    logic [VW+1:0] span_reg;
    logic [VW-1:0] maxy_reg, besty_reg, lft_reg, bx_reg;
    logic          found_reg, ins_reg, fresh_reg, bank_reg;
    logic [VW-1:0] tl_reg, tt_reg, ts_reg;
    logic          tv_reg;
    status_t       st_reg;
    logic          ov_reg;
    logic [1:0]    ost_reg;
    logic [COORD_BITS-1:0] opx_reg, opy_reg;
    logic [VW-1:0] ouh_reg;

    logic          we0, we1;
    logic [AW-1:0] wa, ra;
    logic [EW-1:0] wd, rd0, rd1, rd;

    logic [VW-1:0] rl, rt, rs;
    logic [VW:0]   top_new, e_end, right;
    logic [VW-1:0] sl;
    logic [VW-1:0] maxy_now;
    logic [VW+1:0] span_now;
    logic          cand, bad_size;
    logic          emit, ins_now, merge, last;
    logic [VW-1:0] el, et, es;
    logic [CW:0]   n_final;
    logic          full_now;

    srp_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram0 (
        .clk(clk), .we(we0), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd0));
    srp_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram1 (
        .clk(clk), .we(we1), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd1));

    assign rd = bank_reg ? rd1 : rd0;
    assign rl = fresh_reg ? '0 : {1'b0, rd[EW-1 -: COORD_BITS]};
    assign rt = fresh_reg ? '0 : rd[2*VW-1 -: VW];
    assign rs = fresh_reg ? aw_reg : rd[VW-1:0];

    function automatic logic [VW-1:0] sat(input logic [VW-1:0] v);
        if (v == '0)
            return VW'(1);
        else if (v > LIMIT)
            return LIMIT;
        else
            return v;
    endfunction

    assign top_new = {1'b0, besty_reg} + {1'b0, h_reg};
    assign right   = {1'b0, bx_reg} + {1'b0, w_reg};
    assign e_end   = {1'b0, rl} + {1'b0, rs};
    assign sl      = ({1'b0, rl} < right) ? right[VW-1:0] : rl;

    assign maxy_now = (rt > maxy_reg || j_reg == i_reg) ? rt : maxy_reg;
    assign span_now = span_reg + (VW+2)'(rs);
    assign cand     = span_reg >= (VW+2)'(w_reg) && (!found_reg || maxy_reg < besty_reg);
    assign bad_size = rect_width == '0 || rect_height == '0 ||
                      rect_width > aw_reg || rect_height > ah_reg;

    always_comb
    begin
        ins_now = i_reg == bidx_reg && !ins_reg;
        emit = 1'b0;
        el = rl;
        et = rt;
        es = rs;
        if (ins_now)
        begin
            emit = 1'b1;
            el = bx_reg;
            et = top_new[VW-1:0];
            es = w_reg;
        end
        else if (i_reg < cnt_reg)
        begin
            if (i_reg < bidx_reg)
                emit = 1'b1;
            else if (e_end > right)
            begin
                emit = 1'b1;
                el = sl;
                es = e_end[VW-1:0] - sl;
            end
        end
    end

    assign merge    = tv_reg && et == tt_reg;
    assign last     = i_reg == cnt_reg;
    assign n_final  = {1'b0, n_reg} + (CW+1)'(1);
    assign full_now = n_final > (CW+1)'(MAX_SEGMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            aw_reg    <= VW'(1024);
            ah_reg    <= VW'(1024);
            w_reg     <= '0;
            h_reg     <= '0;
            hi_reg    <= '0;
            cnt_reg   <= CW'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            bidx_reg  <= '0;
            span_reg  <= '0;
            maxy_reg  <= '0;
            besty_reg <= '0;
            lft_reg   <= '0;
            bx_reg    <= '0;
            found_reg <= 1'b0;
            ins_reg   <= 1'b0;
            fresh_reg <= 1'b1;
            bank_reg  <= 1'b0;
            tl_reg    <= '0;
            tt_reg    <= '0;
            ts_reg    <= '0;
            tv_reg    <= 1'b0;
            st_reg    <= ST_PLACED;
            ov_reg    <= 1'b0;
            ost_reg   <= '0;
            opx_reg   <= '0;
            opy_reg   <= '0;
            ouh_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == 1'(REG_ATLAS_WIDTH))
                    aw_reg <= sat(cfg_data);
                else
                    ah_reg <= sat(cfg_data);
                cnt_reg   <= CW'(1);
                hi_reg    <= '0;
                fresh_reg <= 1'b1;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_valid && !in_stall)
                        begin
                            w_reg     <= rect_width;
                            h_reg     <= rect_height;
                            i_reg     <= '0;
                            found_reg <= 1'b0;
                            st_reg    <= bad_size ? ST_INVALID : ST_PLACED;
                        end
                    end
                    S_SCAN_RD:
                    begin
                        j_reg    <= i_reg;
                        span_reg <= '0;
                    end
                    S_SCAN_IN:
                    begin
                        maxy_reg <= maxy_now;
                        span_reg <= span_now;
                        j_reg    <= j_reg + CW'(1);
                        if (j_reg == i_reg)
                            lft_reg <= rl;
                    end
                    S_SCAN_NEXT:
                    begin
                        if (cand)
                        begin
                            found_reg <= 1'b1;
                            besty_reg <= maxy_reg;
                            bidx_reg  <= i_reg;
                            bx_reg    <= lft_reg;
                        end
                        i_reg <= i_reg + CW'(1);
                    end
                    S_CHECK:
                    begin
                        i_reg   <= '0;
                        n_reg   <= '0;
                        tv_reg  <= 1'b0;
                        ins_reg <= 1'b0;
                        if (!found_reg || top_new > {1'b0, ah_reg})
                            st_reg <= ST_NOFIT;
                        else
                            st_reg <= ST_PLACED;
                    end
                    S_BUILD:
                    begin
                        if (emit)
                        begin
                            if (merge)
                            begin
                                ts_reg <= ts_reg + es;
                            end
                            else
                            begin
                                if (tv_reg)
                                    n_reg <= n_reg + CW'(1);
                                tl_reg <= el;
                                tt_reg <= et;
                                ts_reg <= es;
                                tv_reg <= 1'b1;
                            end
                        end
                        if (ins_now)
                            ins_reg <= 1'b1;
                        else
                            i_reg <= i_reg + CW'(1);
                        if (last)
                        begin
                            if (full_now)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                cnt_reg   <= n_final[CW-1:0];
                                bank_reg  <= ~bank_reg;
                                fresh_reg <= 1'b0;
                                if (top_new[VW-1:0] > hi_reg)
                                    hi_reg <= top_new[VW-1:0];
                            end
                        end
                    end
                    S_DONE:
                    begin
                        if (!ov_reg || !out_stall)
                        begin
                            ost_reg <= st_reg;
                            ouh_reg <= hi_reg;
                            if (st_reg == ST_PLACED)
                            begin
                                opx_reg <= bx_reg[COORD_BITS-1:0];
                                opy_reg <= besty_reg[COORD_BITS-1:0];
                            end
                            else
                            begin
                                opx_reg <= '0;
                                opy_reg <= '0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall = 1'b1;
        we0 = 1'b0;
        we1 = 1'b0;
        wa = n_reg[AW-1:0];
        wd = {tl_reg[COORD_BITS-1:0], tt_reg, ts_reg};
        ra = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = cfg_we;
                if (in_valid && !cfg_we)
                begin
                    if (bad_size)
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                ra = i_reg[AW-1:0];
                state_next = S_SCAN_IN;
            end
            S_SCAN_IN:
            begin
                ra = AW'(j_reg + CW'(1));
                if (j_reg + CW'(1) < cnt_reg && span_now < (VW+2)'(w_reg))
                    state_next = S_SCAN_IN;
                else
                    state_next = S_SCAN_NEXT;
            end
            S_SCAN_NEXT:
            begin
                if (i_reg + CW'(1) < cnt_reg)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!found_reg || top_new > {1'b0, ah_reg})
                    state_next = S_DONE;
                else
                    state_next = S_BUILD_RD;
            end
            S_BUILD_RD:
            begin
                ra = i_reg[AW-1:0];
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                ra = ins_now ? i_reg[AW-1:0] : AW'(i_reg + CW'(1));
                if (((emit && tv_reg && !merge) || last) && n_reg < CW'(MAX_SEGMENTS))
                begin
                    we0 = bank_reg;
                    we1 = ~bank_reg;
                end
                if (last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign pos_x       = opx_reg;
    assign pos_y       = opy_reg;
    assign used_height = ouh_reg;

endmodule

@@ rtl/core/srp_checker.sv @@
module srp_checker
    import srp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [11:0] pos_x,
    input logic [11:0] pos_y,
    input logic [12:0] used_height
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(pos_x)
            && $stable(pos_y) && $stable(used_height))
        else $error("result dropped while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PLACED |-> pos_x == '0 && pos_y == '0)
        else $error("rejected result carries a position");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request dropped while stalled");

    a_place_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PLACED |-> {1'b0, pos_y} < used_height)
        else $error("placed rectangle above used height");

endmodule

bind skyline_rect_packer_top srp_checker u_srp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .pos_x(pos_x), .pos_y(pos_y), .used_height(used_height));

@@ test/skyline_rect_packer_top_tb.sv @@
`timescale 1ns / 1ps

module skyline_rect_packer_top_tb
    import srp_pkg::*;
();

    localparam int NSEG  = 64;
    localparam int LIMIT = 1 << 12;
    localparam int QUIET = 40;
    localparam longint MAX_CYCLES = 30000000;

    typedef enum logic [1:0] { K_ITEM, K_CFG, K_DRAIN, K_MODE } job_kind_t;

    typedef struct {
        job_kind_t kind;
        int        a;
        int        b;
    } job_t;

    typedef struct {
        status_t     st;
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] used;
    } placement_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [12:0] rect_width = '0;
    logic [12:0] rect_height = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] used_height;

    skyline_rect_packer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .used_height (used_height)
    );

    job_t       jobs[$];
    placement_t placements[$];
    int         send_idle = 10;
    int         recv_idle = 71;
    int         quiet_cycles = 0;
    int         mismatches = 0;
    longint     cycles = 0;

    int atlas_w, atlas_h, sky_count, sky_high;
    int sky_left[NSEG], sky_top[NSEG], sky_span[NSEG];

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int clamp_size(int v);
        if (v == 0)
            return 1;
        if (v > LIMIT)
            return LIMIT;
        return v;
    endfunction

    function automatic void clear_sky();
        sky_left[0] = 0;
        sky_top[0]  = 0;
        sky_span[0] = atlas_w;
        sky_count   = 1;
        sky_high    = 0;
    endfunction

    function automatic void write_size(int idx, int v);
        if (idx == REG_ATLAS_WIDTH)
            atlas_w = clamp_size(v);
        else
            atlas_h = clamp_size(v);
        clear_sky();
    endfunction

    function automatic placement_t place_rect(int w, int h);
        placement_t r;
        int nl[NSEG+1], nt[NSEG+1], ns[NSEG+1];
        int i, j, n, span, maxy, best_i, best_y, bx, right, l, e;
        bit found;
        r.st = ST_PLACED;
        r.x = '0;
        r.y = '0;
        found = 0;
        best_i = 0;
        best_y = 0;
        if (w == 0 || h == 0 || w > atlas_w || h > atlas_h)
        begin
            r.st = ST_INVALID;
            r.used = 13'(sky_high);
            return r;
        end
        for (i = 0; i < sky_count; i++)
        begin
            span = 0;
            maxy = sky_top[i];
            for (j = i; j < sky_count && span < w; j++)
            begin
                if (sky_top[j] > maxy)
                    maxy = sky_top[j];
                span += sky_span[j];
            end
            if (span >= w && (!found || maxy < best_y))
            begin
                found = 1;
                best_y = maxy;
                best_i = i;
            end
        end
        if (!found || best_y + h > atlas_h)
        begin
            r.st = ST_NOFIT;
            r.used = 13'(sky_high);
            return r;
        end
        bx = sky_left[best_i];
        right = bx + w;
        n = 0;
        for (i = 0; i < best_i; i++)
        begin
            nl[n] = sky_left[i];
            nt[n] = sky_top[i];
            ns[n] = sky_span[i];
            n++;
        end
        nl[n] = bx;
        nt[n] = best_y + h;
        ns[n] = w;
        n++;
        for (i = best_i; i < sky_count; i++)
        begin
            l = sky_left[i];
            e = l + sky_span[i];
            if (e > right)
            begin
                if (l < right)
                    l = right;
                nl[n] = l;
                nt[n] = sky_top[i];
                ns[n] = e - l;
                n++;
            end
        end
        j = 0;
        for (i = 1; i < n; i++)
        begin
            if (nt[i] == nt[j])
                ns[j] += ns[i];
            else
            begin
                j++;
                nl[j] = nl[i];
                nt[j] = nt[i];
                ns[j] = ns[i];
            end
        end
        n = j + 1;
        if (n > NSEG)
        begin
            r.st = ST_FULL;
            r.used = 13'(sky_high);
            return r;
        end
        for (i = 0; i < n; i++)
        begin
            sky_left[i] = nl[i];
            sky_top[i]  = nt[i];
            sky_span[i] = ns[i];
        end
        sky_count = n;
        if (best_y + h > sky_high)
            sky_high = best_y + h;
        r.x = 12'(bx);
        r.y = 12'(best_y);
        r.used = 13'(sky_high);
        return r;
    endfunction

    function automatic void add_job(job_kind_t k, int a, int b);
        job_t j;
        j.kind = k;
        j.a = a;
        j.b = b;
        jobs.insert(jobs.size(), j);
    endfunction

    function automatic int pick_size(int lim);
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return 0;
        if (sel < 7)
            return 8191;
        if (sel < 10)
            return $urandom_range(8191);
        if (sel < 13)
            return lim;
        if (sel < 70)
            return $urandom_range((lim + 3) / 4 > 1 ? (lim + 3) / 4 : 1, 1);
        return $urandom_range(lim, 1);
    endfunction

    function automatic int pick_atlas();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return 8191;
            4: return $urandom_range(8191);
            default: return $urandom_range(512, 8);
        endcase
    endfunction

    initial
    begin
        int g, k, wl, hl, wv, hv;
        atlas_w = 1024;
        atlas_h = 1024;
        clear_sky();

        add_job(K_ITEM, 0, 5);
        add_job(K_ITEM, 5, 0);
        add_job(K_ITEM, 8191, 8191);
        add_job(K_ITEM, 1025, 4);
        add_job(K_ITEM, 4, 1025);
        add_job(K_ITEM, 300, 200);
        add_job(K_ITEM, 300, 700);
        add_job(K_ITEM, 1024, 1024);
        add_job(K_ITEM, 724, 125);
        add_job(K_ITEM, 1024, 1);
        add_job(K_CFG, REG_ATLAS_WIDTH, 0);
        add_job(K_CFG, REG_ATLAS_HEIGHT, 8191);
        add_job(K_ITEM, 1, 4096);
        add_job(K_ITEM, 2, 1);
        add_job(K_ITEM, 1, 1);
        add_job(K_CFG, REG_ATLAS_WIDTH, 4096);
        add_job(K_CFG, REG_ATLAS_HEIGHT, 1);
        add_job(K_ITEM, 4096, 1);
        add_job(K_ITEM, 1, 1);
        add_job(K_ITEM, 4097, 1);

        // alternating columns fill the segment table
        add_job(K_CFG, REG_ATLAS_WIDTH, 65);
        add_job(K_CFG, REG_ATLAS_HEIGHT, 4096);
        for (k = 0; k < 66; k++)
            add_job(K_ITEM, 1, 1 + (k % 2));
        add_job(K_ITEM, 3, 7);

        for (g = 0; g < 93; g++)
        begin
            if (g == 31)
                add_job(K_MODE, 71, 10);
            if (g == 62)
                add_job(K_MODE, 0, 0);
            if (g == 45)
                add_job(K_DRAIN, 0, 0);
            wv = pick_atlas();
            hv = pick_atlas();
            add_job(K_CFG, REG_ATLAS_WIDTH, wv);
            add_job(K_CFG, REG_ATLAS_HEIGHT, hv);
            wl = clamp_size(wv);
            hl = clamp_size(hv);
            for (k = 0; k < 20; k++)
                add_job(K_ITEM, pick_size(wl), pick_size(hl));
        end
        add_job(K_DRAIN, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (jobs.size() == 0 && !in_valid && placements.size() == 0);
        repeat (QUIET) @(posedge clk);
        if (mismatches == 0 && placements.size() == 0)
            $display("skyline_rect_packer_top_tb: PASS");
        else
            $display("skyline_rect_packer_top_tb: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("skyline_rect_packer_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        logic v, we;
        job_t j;
        if (rst_n)
        begin
            v = in_valid;
            we = 1'b0;
            if (in_valid && !in_stall)
            begin
                placements.insert(placements.size(),
                                  place_rect(int'(rect_width), int'(rect_height)));
                v = 1'b0;
            end
            if (placements.size() == 0 && !v)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!v && jobs.size() > 0)
            begin
                j = jobs[0];
                case (j.kind)
                    K_MODE:
                    begin
                        send_idle = j.a;
                        recv_idle = j.b;
                        void'(jobs.pop_front());
                    end
                    K_CFG, K_DRAIN:
                    begin
                        if (quiet_cycles >= QUIET)
                        begin
                            if (j.kind == K_CFG)
                            begin
                                we = 1'b1;
                                cfg_index <= j.a[0];
                                cfg_data <= j.b[12:0];
                                write_size(j.a, j.b);
                            end
                            quiet_cycles = 0;
                            void'(jobs.pop_front());
                        end
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= send_idle)
                        begin
                            v = 1'b1;
                            rect_width <= j.a[12:0];
                            rect_height <= j.b[12:0];
                            void'(jobs.pop_front());
                        end
                    end
                endcase
            end
            in_valid <= v;
            cfg_we <= we;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        placement_t p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (placements.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d x %0d y %0d used %0d",
                             status, pos_x, pos_y, used_height);
            end
            else
            begin
                p = placements.pop_front();
                if (status !== p.st || pos_x !== p.x || pos_y !== p.y
                    || used_height !== p.used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 p.st, p.x, p.y, p.used,
                                 status, pos_x, pos_y, used_height);
                end
            end
        end
    end

endmodule

@@ skyline_rect_packer_top.f @@
rtl/core/srp_pkg.sv
rtl/core/srp_ram.sv
rtl/core/skyline_rect_packer_top.sv
rtl/core/srp_checker.sv
test/skyline_rect_packer_top_tb.sv
